// ===== hdl/cpu_fault_error_accounting_top_macros.svh =====
// assertion macros for the error accounting block
`ifndef CPU_FAULT_ERROR_ACCOUNTING_TOP_MACROS_SVH
`define CPU_FAULT_ERROR_ACCOUNTING_TOP_MACROS_SVH

// same-cycle implication
`define CFEA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFEA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfea_pkg.sv =====
`default_nettype none

package cfea_pkg;

    localparam int CPU_W      = 8;
    localparam int SEV_W      = 2;
    localparam int TYPE_W     = 16;
    localparam int TIME_W     = 64;
    localparam int CNT_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int HEALTH_W   = 2;
    localparam int WINDOW_W   = 46;
    localparam int PIN_BITS   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // severity codes
    localparam logic [SEV_W-1:0] SEV_CE    = 2'd0;
    localparam logic [SEV_W-1:0] SEV_REC   = 2'd1;
    localparam logic [SEV_W-1:0] SEV_FATAL = 2'd2;

    // health codes
    localparam logic [HEALTH_W-1:0] HEALTH_ONLINE    = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED  = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_ISOLATING = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_COUNTED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DEGRADED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ISOLATE   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_L3_EXEMPT = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ISOLATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_L3_UCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CE_THR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UCE_THR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PINNED_MASK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L3_TYPE_CODE = 3'd6;

    typedef struct packed {
        logic [CPU_W-1:0]  cpu_index;
        logic [SEV_W-1:0]  severity;
        logic [TYPE_W-1:0] err_bits;
        logic [TIME_W-1:0] time_ns;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HEALTH_W-1:0] health_out;
        logic                isolate_fatal;
        logic [CNT_W-1:0]    ce_in_window;
        logic [CNT_W-1:0]    uce_in_window;
        logic [TYPE_W-1:0]   types_seen;
    } t_rsp;

    typedef struct packed {
        logic [HEALTH_W-1:0] health;
        logic [CNT_W-1:0]    ce_cnt;
        logic [CNT_W-1:0]    uce_cnt;
        logic [TYPE_W-1:0]   seen_mask;
        logic [TIME_W-1:0]   begin_ns;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                auto_isolate;
        logic                l3_uce_iso;
        logic [CNT_W-1:0]    ce_threshold;
        logic [CNT_W-1:0]    uce_threshold;
        logic [WINDOW_W-1:0] win_len_ns;
        logic [PIN_BITS-1:0] pinned_mask;
        logic [TYPE_W-1:0]   l3_type_code;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/cpu_fault_error_accounting_top.sv =====
// channel   direction  handshake                  payload
// request   in         i_start, o_busy            i_req  (cfea_pkg::t_req)
// result    out        o_done (one-cycle strobe)  o_rsp  (cfea_pkg::t_rsp)
// config    in         i_cfg_we, i_cfg_idx        i_cfg_wdata
//
// one request per cycle while o_busy is low; its result is on o_rsp with o_done, after
// stage 1 and the result register
// latency is set by the registered read of the per-cpu table ram plus the result register
// o_busy is high through reset and until r_rdy sets after reset releases, then the block never stalls
// synchronous active-low reset clears the health table via per-entry valid bits, no sweep
// the receiver cannot stall: o_done is a single-cycle strobe with o_rsp alongside

`default_nettype none

module cpu_fault_error_accounting_top #(
    parameter int NUM_CPUS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire cfea_pkg::t_req                      i_req,
    output logic                                     o_done,
    output cfea_pkg::t_rsp                           o_rsp,
    input  wire logic                                i_cfg_we,
    input  wire logic [cfea_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cfea_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

`include "cpu_fault_error_accounting_top_macros.svh"

    localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // ready flag, low through reset
    logic r_rdy;
    logic w_acc;

    // configuration
    cfea_pkg::t_cfg                r_cfg;
    logic [cfea_pkg::WINDOW_W-1:0] w_win_prod;

    // stage 1: request waiting on the table read
    logic           r_s1_vld;
    cfea_pkg::t_req r_s1_req;

    // table storage and valid bits
    logic [NUM_CPUS-1:0]      r_vld;
    logic [cfea_pkg::ENTRY_W-1:0] w_ram_rdata;
    logic [AW-1:0]            w_idx;
    logic                     w_cpu_ok;

    // write-back forwarding for back-to-back requests to one cpu
    logic             r_fw_vld;
    logic [AW-1:0]    r_fw_idx;
    cfea_pkg::t_entry r_fw_entry;

    cfea_pkg::t_entry w_entry;
    cfea_pkg::t_entry w_upd_entry;
    logic             w_upd_we;
    logic             w_we;
    cfea_pkg::t_rsp   w_rsp;

    // result register
    logic           r_out_vld;
    cfea_pkg::t_rsp r_out;

    assign o_busy = ~r_rdy;
    assign w_acc  = i_start & r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    // window length kept in ns so the request path only subtracts and compares
    assign w_win_prod = cfea_pkg::WINDOW_W'(i_cfg_wdata[cfea_pkg::CNT_W-1:0]) *
                        cfea_pkg::WINDOW_W'(cfea_pkg::NS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_isolate  <= 1'b1;
            r_cfg.l3_uce_iso    <= 1'b0;
            r_cfg.ce_threshold  <= 16'd10;
            r_cfg.uce_threshold <= 16'd1;
            r_cfg.win_len_ns    <= 46'd60000000000;
            r_cfg.pinned_mask   <= '0;
            r_cfg.l3_type_code  <= 16'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfea_pkg::REG_AUTO_ISOLATE: r_cfg.auto_isolate <= i_cfg_wdata[0];
                cfea_pkg::REG_ISO_L3_UCE:   r_cfg.l3_uce_iso   <= i_cfg_wdata[0];
                cfea_pkg::REG_CE_THR:
                    r_cfg.ce_threshold  <= i_cfg_wdata[cfea_pkg::CNT_W-1:0];
                cfea_pkg::REG_UCE_THR:
                    r_cfg.uce_threshold <= i_cfg_wdata[cfea_pkg::CNT_W-1:0];
                cfea_pkg::REG_WINDOW_SECS:  r_cfg.win_len_ns  <= w_win_prod;
                cfea_pkg::REG_PINNED_MASK:  r_cfg.pinned_mask <= i_cfg_wdata;
                cfea_pkg::REG_L3_TYPE_CODE:
                    r_cfg.l3_type_code  <= i_cfg_wdata[cfea_pkg::TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_req <= i_req;
        end
    end

    assign w_idx    = r_s1_req.cpu_index[AW-1:0];
    assign w_cpu_ok = {1'b0, r_s1_req.cpu_index} < (cfea_pkg::CPU_W+1)'(NUM_CPUS);
    assign w_we     = r_s1_vld & w_upd_we;

    cfea_ram #(
        .WIDTH (cfea_pkg::ENTRY_W),
        .DEPTH (NUM_CPUS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_upd_entry),
        .i_raddr (i_req.cpu_index[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // the ram read at accept misses a write landing on the same edge, so take the
    // forwarded copy; an entry never written since reset reads as all zero
    always_comb begin
        if (r_fw_vld && r_fw_idx == w_idx) begin
            w_entry = r_fw_entry;
        end else if (w_cpu_ok && r_vld[w_idx]) begin
            w_entry = w_ram_rdata;
        end else begin
            w_entry = '0;
        end
    end

    cfea_update u_update (
        .i_req    (r_s1_req),
        .i_cpu_ok (w_cpu_ok),
        .i_entry  (w_entry),
        .i_cfg    (r_cfg),
        .o_entry  (w_upd_entry),
        .o_we     (w_upd_we),
        .o_rsp    (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= w_we;
            if (w_we) begin
                r_vld[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fw_idx   <= w_idx;
            r_fw_entry <= w_upd_entry;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_out <= w_rsp;
        end
    end

    assign o_done = r_out_vld;
    assign o_rsp  = r_out;

    // every result traces back to a request accepted through stage 1 and the result register
    `CFEA_ASSERT_IMP(a_done_follows_req, i_clk, i_rst_n, o_done && $past(i_rst_n, 2), $past(w_acc, 2), "result without a matching request")
    // table is only written for a request in stage 1 with a valid cpu
    `CFEA_ASSERT_IMP(a_we_valid_cpu, i_clk, i_rst_n, w_we, r_s1_vld && w_cpu_ok, "table write without a valid request")
    // invalid cpu reports carry all-zero fields
    `CFEA_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_done && o_rsp.status == cfea_pkg::STATUS_INVALID, o_rsp.health_out == '0 && o_rsp.ce_in_window == '0 && o_rsp.uce_in_window == '0 && o_rsp.types_seen == '0, "invalid cpu result not zero")
    // fatal flag only with a fresh isolation, which leaves the cpu isolating
    `CFEA_ASSERT_IMP(a_fatal_isolate, i_clk, i_rst_n, o_done && o_rsp.isolate_fatal, o_rsp.status == cfea_pkg::STATUS_ISOLATE && o_rsp.health_out == cfea_pkg::HEALTH_ISOLATING, "fatal flag outside isolation")

endmodule

`default_nettype wire

// ===== hdl/cfea_ram.sv =====
`default_nettype none

module cfea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/cfea_update.sv =====
`default_nettype none

module cfea_update (
    input  wire cfea_pkg::t_req   i_req,
    input  wire logic             i_cpu_ok,
    input  wire cfea_pkg::t_entry i_entry,
    input  wire cfea_pkg::t_cfg   i_cfg,
    output cfea_pkg::t_entry      o_entry,
    output logic                  o_we,
    output cfea_pkg::t_rsp        o_rsp
);

    function automatic logic [cfea_pkg::CNT_W-1:0] sat_inc(
        input logic [cfea_pkg::CNT_W-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    logic [cfea_pkg::TIME_W-1:0]   w_elapsed;
    logic                          w_expired;
    logic [cfea_pkg::CNT_W-1:0]    w_ce0, w_uce0, w_ce1, w_uce1;
    logic [cfea_pkg::TYPE_W-1:0]   w_seen0, w_seen1;
    logic [cfea_pkg::TIME_W-1:0]   w_begin;
    logic                          w_pinned;
    logic                          w_uce_hit;
    logic [cfea_pkg::HEALTH_W-1:0] w_st;
    logic [cfea_pkg::STATUS_W-1:0] w_status;
    logic                          w_fatal;

    // window restart
    assign w_elapsed = i_req.time_ns - i_entry.begin_ns;
    assign w_expired = w_elapsed > {{(cfea_pkg::TIME_W-cfea_pkg::WINDOW_W){1'b0}},
                                    i_cfg.win_len_ns};
    assign w_ce0   = w_expired ? '0 : i_entry.ce_cnt;
    assign w_uce0  = w_expired ? '0 : i_entry.uce_cnt;
    assign w_seen0 = w_expired ? '0 : i_entry.seen_mask;
    assign w_begin = w_expired ? i_req.time_ns : i_entry.begin_ns;

    assign w_ce1   = (i_req.severity == cfea_pkg::SEV_CE) ? sat_inc(w_ce0) : w_ce0;
    assign w_uce1  = (i_req.severity == cfea_pkg::SEV_REC ||
                      i_req.severity == cfea_pkg::SEV_FATAL) ? sat_inc(w_uce0) : w_uce0;
    assign w_seen1 = w_seen0 | i_req.err_bits;

    assign w_pinned = (i_req.cpu_index < cfea_pkg::CPU_W'(cfea_pkg::PIN_BITS)) &&
                      i_cfg.pinned_mask[i_req.cpu_index[$clog2(cfea_pkg::PIN_BITS)-1:0]];
    assign w_uce_hit = w_uce1 >= i_cfg.uce_threshold;

    always_comb begin
        w_st     = i_entry.health;
        w_status = cfea_pkg::STATUS_COUNTED;
        w_fatal  = 1'b0;
        if (i_cfg.auto_isolate && !w_pinned) begin
            if (i_req.err_bits == i_cfg.l3_type_code && !i_cfg.l3_uce_iso &&
                w_uce_hit) begin
                w_status = cfea_pkg::STATUS_L3_EXEMPT;
            end else if (w_uce_hit) begin
                w_st     = cfea_pkg::HEALTH_ISOLATING;
                w_status = cfea_pkg::STATUS_ISOLATE;
                w_fatal  = (i_req.severity == cfea_pkg::SEV_FATAL);
            end else if (i_entry.health == cfea_pkg::HEALTH_ONLINE &&
                         w_ce1 >= i_cfg.ce_threshold) begin
                w_st     = cfea_pkg::HEALTH_DEGRADED;
                w_status = cfea_pkg::STATUS_DEGRADED;
            end
        end
    end

    always_comb begin
        o_entry.health    = w_st;
        o_entry.ce_cnt    = w_ce1;
        o_entry.uce_cnt   = w_uce1;
        o_entry.seen_mask = w_seen1;
        o_entry.begin_ns  = w_begin;
        o_we              = 1'b0;
        o_rsp             = '0;
        if (!i_cpu_ok) begin
            o_rsp.status = cfea_pkg::STATUS_INVALID;
        end else if (i_entry.health == cfea_pkg::HEALTH_ISOLATING) begin
            o_rsp.status        = cfea_pkg::STATUS_IGNORED;
            o_rsp.health_out    = cfea_pkg::HEALTH_ISOLATING;
            o_rsp.ce_in_window  = i_entry.ce_cnt;
            o_rsp.uce_in_window = i_entry.uce_cnt;
            o_rsp.types_seen    = i_entry.seen_mask;
        end else begin
            o_we                = 1'b1;
            o_rsp.status        = w_status;
            o_rsp.health_out    = w_st;
            o_rsp.isolate_fatal = w_fatal;
            o_rsp.ce_in_window  = w_ce1;
            o_rsp.uce_in_window = w_uce1;
            o_rsp.types_seen    = w_seen1;
        end
    end

endmodule

`default_nettype wire
